// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, switched off while reset is low.
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Implication checked in the next cycle, switched off while reset is low.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("check failed");

// Implication checked in the next cycle, active during reset as well.
`define CHK_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: sv/llsh_pkg.sv
`default_nettype none

package llsh_pkg;

    localparam int unsigned LLSH_MAX_LAYERS = 256;

    localparam logic [63:0] SEED_VALUE   = 64'h243F6A8885A308D3;
    localparam logic [63:0] MISSING_MARK = 64'h00000000DEADBEEF;
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] FIN_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] FIN_MUL_B    = 64'h94D049BB133111EB;

    localparam logic OP_START = 1'b0;
    localparam logic OP_LAYER = 1'b1;

endpackage

`default_nettype wire

// File: sv/llsh_mix.sv
`default_nettype none

module llsh_mix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_h,
    input  logic [63:0] i_v,
    output logic        o_done,
    output logic [63:0] o_k
);
    import llsh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COMB,
        S_XS1,
        S_ML0,
        S_ML1,
        S_ML2,
        S_ML3,
        S_XS2,
        S_XS3
    } t_state;

    t_state      r_state;
    logic [63:0] r_h;
    logic [63:0] r_v;
    logic [63:0] r_k;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic        r_second;
    logic        r_done;

    logic [63:0] w_const;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul;

    assign w_const = r_second ? FIN_MUL_B : FIN_MUL_A;
    assign w_mul_a = (r_state == S_ML2) ? r_k[63:32] : r_k[31:0];
    assign w_mul_b = (r_state == S_ML1) ? w_const[63:32] : w_const[31:0];
    assign w_mul   = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= (r_state == S_XS3);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_h     <= i_h;
                        r_v     <= i_v;
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    r_k      <= r_h ^ (r_v + GOLDEN_GAMMA + (r_h << 6) + (r_h >> 2));
                    r_second <= 1'b0;
                    r_state  <= S_XS1;
                end
                S_XS1: begin
                    r_k     <= r_k ^ (r_k >> 30);
                    r_state <= S_ML0;
                end
                S_ML0: begin
                    r_prod  <= w_mul;
                    r_state <= S_ML1;
                end
                S_ML1: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_ML2;
                end
                S_ML2: begin
                    r_acc   <= r_acc + {r_prod[31:0], 32'd0};
                    r_prod  <= w_mul;
                    r_state <= S_ML3;
                end
                S_ML3: begin
                    r_k     <= r_acc + {r_prod[31:0], 32'd0};
                    r_state <= r_second ? S_XS3 : S_XS2;
                end
                S_XS2: begin
                    r_k      <= r_k ^ (r_k >> 27);
                    r_second <= 1'b1;
                    r_state  <= S_ML0;
                end
                S_XS3: begin
                    r_k     <= r_k ^ (r_k >> 31);
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_k    = r_k;

endmodule

`default_nettype wire

// File: sv/layer_list_signature_hash_unit.sv
// Layer list signature unit. A start item seeds a 64-bit running hash from the
// clamped layer count, each layer item then folds in its id and either a
// missing marker or its opacity, blend code, visible flag, clip flag and
// revision, and the item marked last delivers the hash as its result. All
// mixing runs on one shared mix unit whose single 32x32 multiplier is used
// three times for each of the two 64-bit products of a mix. The input stalls
// from the acceptance of an item until its last mix is done and, for an item
// marked last, until its result register is loaded, so no new item is taken
// before the last one is finished. A finished result waits in its own
// register; only the loading of a later result waits for it to be taken.
`default_nettype none

module layer_list_signature_hash_unit #(
    parameter int unsigned MAX_LAYERS = llsh_pkg::LLSH_MAX_LAYERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [0:0]  i_opcode,
    input  logic [8:0]  i_layer_count,
    input  logic [31:0] i_layer_id,
    input  logic [0:0]  i_present,
    input  logic [31:0] i_opacity_bits,
    input  logic [4:0]  i_blend_code,
    input  logic [0:0]  i_is_visible,
    input  logic [0:0]  i_clips_below,
    input  logic [63:0] i_revision,
    input  logic [0:0]  i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_signature
);
    import llsh_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        F_ID,
        F_OPACITY,
        F_BLEND,
        F_VISIBLE,
        F_CLIP,
        F_REVISION
    } t_field;

    localparam logic [2:0] MIXES_LEFT_PRESENT = 3'd5;
    localparam logic [2:0] MIXES_LEFT_MISSING = 3'd1;
    localparam logic [2:0] MIXES_LEFT_START   = 3'd0;

    t_state      r_state;
    logic [63:0] r_hash;
    logic        r_present;
    logic [31:0] r_opacity;
    logic [4:0]  r_blend;
    logic        r_visible;
    logic        r_clip;
    logic [63:0] r_revision;
    logic        r_last;
    t_field      r_field;
    logic [2:0]  r_left;
    logic        r_mix_start;
    logic [63:0] r_mix_h;
    logic [63:0] r_mix_v;
    logic        r_out_valid;
    logic [63:0] r_out_sig;

    logic [15:0] w_count;
    logic [15:0] w_count_clamped;
    t_field      w_next_field;
    logic [63:0] w_next_v;
    logic        w_mix_done;
    logic [63:0] w_mix_k;

    assign w_count         = {7'd0, i_layer_count};
    assign w_count_clamped = (w_count > 16'(MAX_LAYERS)) ? 16'(MAX_LAYERS) : w_count;
    assign w_next_field    = t_field'(r_field + 3'd1);

    always_comb begin
        case (w_next_field)
            F_OPACITY:  w_next_v = r_present ? {32'd0, r_opacity} : MISSING_MARK;
            F_BLEND:    w_next_v = {59'd0, r_blend};
            F_VISIBLE:  w_next_v = {63'd0, r_visible};
            F_CLIP:     w_next_v = {63'd0, r_clip};
            F_REVISION: w_next_v = r_revision;
            default:    w_next_v = 64'd0;
        endcase
    end

    llsh_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mix_start),
        .i_h     (r_mix_h),
        .i_v     (r_mix_v),
        .o_done  (w_mix_done),
        .o_k     (w_mix_k)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= 64'd0;
            r_mix_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_mix_start <= i_valid;
                    if (i_valid) begin
                        r_present   <= i_present;
                        r_opacity   <= i_opacity_bits;
                        r_blend     <= i_blend_code;
                        r_visible   <= i_is_visible;
                        r_clip      <= i_clips_below;
                        r_revision  <= i_revision;
                        r_last      <= i_last;
                        r_field     <= F_ID;
                        if (i_opcode == OP_LAYER) begin
                            r_mix_h <= r_hash;
                            r_mix_v <= {32'd0, i_layer_id};
                            r_left  <= i_present ? MIXES_LEFT_PRESENT : MIXES_LEFT_MISSING;
                        end else begin
                            r_mix_h <= SEED_VALUE;
                            r_mix_v <= {48'd0, w_count_clamped};
                            r_left  <= MIXES_LEFT_START;
                        end
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    r_mix_start <= w_mix_done && (r_left != 3'd0);
                    if (w_mix_done) begin
                        r_hash <= w_mix_k;
                        if (r_left == 3'd0) begin
                            r_state <= r_last ? S_EMIT : S_IDLE;
                        end else begin
                            r_left      <= r_left - 3'd1;
                            r_field     <= w_next_field;
                            r_mix_h     <= w_mix_k;
                            r_mix_v     <= w_next_v;
                        end
                    end
                end
                S_EMIT: begin
                    r_mix_start <= 1'b0;
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_sig   <= r_hash;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_mix_start <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_signature = r_out_sig;

endmodule

`default_nettype wire

// File: sv/llsh_checker.sv
`default_nettype none
`include "assert_macros.svh"

module llsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_signature
);

    // A result that is held back keeps its value until it is taken.
    `CHK_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_signature))

    // An accepted item always occupies the block in the following cycle.
    `CHK_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)

    // A new result only appears at the end of an item's work.
    `CHK_SAME(a_result_after_work, $rose(o_valid), $past(o_stall))

    // Reset leaves no result pending.
    `CHK_NEXT_ALWAYS(a_reset_clears_out, !i_rst_n, !o_valid)

endmodule

bind layer_list_signature_hash_unit llsh_checker u_llsh_checker (.*);

`default_nettype wire

// File: dv/layer_list_signature_hash_unit_test.sv
`default_nettype none

module layer_list_signature_hash_unit_test;

    import llsh_pkg::*;

    localparam logic [63:0] HASH_SEED   = 64'h243F6A8885A308D3;
    localparam logic [63:0] ABSENT_MARK = 64'h00000000DEADBEEF;
    localparam logic [63:0] GAMMA_STEP  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SCRAMBLE_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SCRAMBLE_B  = 64'h94D049BB133111EB;
    localparam int          COUNT_LIMIT = 256;
    localparam int          ITEM_TARGET = 1550;
    localparam int          DRAIN_CYCLES = 150;

    typedef struct packed {
        logic        op;
        logic [8:0]  count;
        logic [31:0] id;
        logic        present;
        logic [31:0] opacity;
        logic [4:0]  blend;
        logic        visible;
        logic        clip;
        logic [63:0] revision;
        logic        last;
    } t_layer_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_stall = 1'b0;
    t_layer_item drive_item = '0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_signature;

    t_layer_item pending_items[$];
    logic [63:0] expected_sigs[$];
    logic [63:0] signature_state = '0;

    int items_total = 0;
    int items_accepted = 0;
    int sigs_checked = 0;
    int lists_started = 0;
    int absent_layers = 0;
    int failures = 0;
    int mismatches = 0;
    int send_gap = 0;
    int hold_left = 0;
    bit calm_phase = 1'b0;

    layer_list_signature_hash_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_opcode       (drive_item.op),
        .i_layer_count  (drive_item.count),
        .i_layer_id     (drive_item.id),
        .i_present      (drive_item.present),
        .i_opacity_bits (drive_item.opacity),
        .i_blend_code   (drive_item.blend),
        .i_is_visible   (drive_item.visible),
        .i_clips_below  (drive_item.clip),
        .i_revision     (drive_item.revision),
        .i_last         (drive_item.last),
        .o_valid        (o_valid),
        .i_stall        (out_stall),
        .o_signature    (o_signature)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic enqueue_item(input t_layer_item it);
        pending_items = {pending_items, it};
    endtask

    function automatic logic [63:0] fold_value(input logic [63:0] h, input logic [63:0] v);
        logic [63:0] k;
        k = h ^ (v + GAMMA_STEP + (h << 6) + (h >> 2));
        k = k ^ (k >> 30);
        k = k * SCRAMBLE_A;
        k = k ^ (k >> 27);
        k = k * SCRAMBLE_B;
        k = k ^ (k >> 31);
        return k;
    endfunction

    task automatic predict_signature(input t_layer_item it);
        logic [63:0] h;
        logic [63:0] n;
        h = signature_state;
        if (it.op == OP_START) begin
            n = (it.count > COUNT_LIMIT) ? 64'(COUNT_LIMIT) : 64'(it.count);
            h = fold_value(HASH_SEED, n);
            lists_started++;
        end else begin
            h = fold_value(h, 64'(it.id));
            if (!it.present) begin
                h = fold_value(h, ABSENT_MARK);
                absent_layers++;
            end else begin
                h = fold_value(h, 64'(it.opacity));
                h = fold_value(h, 64'(it.blend));
                h = fold_value(h, 64'(it.visible));
                h = fold_value(h, 64'(it.clip));
                h = fold_value(h, it.revision);
            end
        end
        signature_state = h;
        if (it.last) begin
            expected_sigs = {expected_sigs, h};
        end
    endtask

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [63:0] wide_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_layer_item make_item(input logic op, input logic [8:0] count,
                                              input logic [31:0] id, input logic present,
                                              input logic [31:0] opacity, input logic [4:0] blend,
                                              input logic visible, input logic clip,
                                              input logic [63:0] revision, input logic last);
        t_layer_item it;
        it.op = op;
        it.count = count;
        it.id = id;
        it.present = present;
        it.opacity = opacity;
        it.blend = blend;
        it.visible = visible;
        it.clip = clip;
        it.revision = revision;
        it.last = last;
        return it;
    endfunction

    function automatic t_layer_item random_item(input logic op, input logic present,
                                                input logic last);
        logic [63:0] a;
        logic [63:0] b;
        a = wide_value();
        b = wide_value();
        return make_item(op, 9'($urandom_range(0, 511)), a[31:0], present, b[63:32],
                         5'($urandom_range(0, 31)), 1'($urandom), 1'($urandom),
                         wide_value(), last);
    endfunction

    // Driver: a held item stays on the inputs until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                predict_signature(drive_item);
                items_accepted++;
            end
            if (!(in_valid && o_stall)) begin
                if ($urandom_range(0, 199) == 0) begin
                    calm_phase = ~calm_phase;
                end
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() > 0) begin
                    drive_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= idle_length();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each signature taken and stalls the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_valid && !out_stall) begin
                if (expected_sigs.size() == 0) begin
                    failures++;
                    $display("unexpected signature %h at %0t", o_signature, $time);
                end else begin
                    if (o_signature !== expected_sigs[0]) begin
                        failures++;
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("signature mismatch: expected %h got %h at %0t",
                                     expected_sigs[0], o_signature, $time);
                        end
                    end
                    void'(expected_sigs.pop_front());
                    sigs_checked++;
                end
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 5) == 0) begin
                    hold_left <= idle_length();
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int cnt;
        int clamped;
        int layers;
        logic [63:0] v;

        // Layer item straight after reset, before any start.
        enqueue_item(make_item(OP_LAYER, 9'd0, 32'h0000_0001, 1'b1, 32'h3F80_0000,
                               5'd0, 1'b1, 1'b0, 64'd1, 1'b1));
        // Empty list.
        enqueue_item(make_item(OP_START, 9'd0, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b1));
        // Count at the limit, one layer with every field at its maximum.
        enqueue_item(make_item(OP_START, 9'd256, '1, 1'b1, '1, '1, 1'b1, 1'b1, '1, 1'b0));
        enqueue_item(make_item(OP_LAYER, 9'd511, '1, 1'b1, '1, '1, 1'b1, 1'b1, '1, 1'b1));
        // Count above the limit, then a missing layer whose other fields are ignored.
        enqueue_item(make_item(OP_START, 9'd511, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        enqueue_item(make_item(OP_LAYER, 9'd0, '0, 1'b0, '1, '1, 1'b1, 1'b1, '1, 1'b1));
        enqueue_item(make_item(OP_START, 9'd257, '1, 1'b1, '1, '1, 1'b1, 1'b1, '1, 1'b1));
        // Fewer layers than the count announces.
        enqueue_item(make_item(OP_START, 9'd5, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        enqueue_item(make_item(OP_LAYER, 9'd0, '0, 1'b1, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        enqueue_item(make_item(OP_LAYER, 9'd0, '1, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b1));
        // Layers following an emitted signature, without a new start.
        enqueue_item(make_item(OP_LAYER, 9'd0, 32'h8000_0000, 1'b1, 32'h8000_0000,
                               5'd16, 1'b0, 1'b1, 64'h8000_0000_0000_0000, 1'b0));
        enqueue_item(make_item(OP_LAYER, 9'd0, 32'h1234_5678, 1'b1, 32'h3F00_0000,
                               5'd31, 1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b1));
        // More layers than announced, and a start arriving in the middle of a list.
        enqueue_item(make_item(OP_START, 9'd1, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        for (int i = 0; i < 3; i++) begin
            enqueue_item(random_item(OP_LAYER, 1'(i != 1), 1'b0));
        end
        enqueue_item(make_item(OP_START, 9'd2, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        enqueue_item(random_item(OP_LAYER, 1'b1, 1'b0));
        enqueue_item(random_item(OP_LAYER, 1'b0, 1'b1));
        enqueue_item(make_item(OP_START, 9'd256, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b1));

        while (pending_items.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 8) begin
                enqueue_item(random_item(1'($urandom), 1'($urandom),
                                         1'($urandom_range(0, 3) == 0)));
            end else begin
                cnt = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 8) : $urandom_range(0, 511);
                clamped = (cnt > COUNT_LIMIT) ? COUNT_LIMIT : cnt;
                layers = (clamped <= 8) ? clamped : $urandom_range(0, 8);
                if ($urandom_range(0, 49) == 0) begin
                    layers = clamped;
                end
                if ($urandom_range(0, 6) == 0) begin
                    layers = $urandom_range(0, 10);
                end
                v = wide_value();
                enqueue_item(make_item(OP_START, 9'(cnt), v[31:0], 1'($urandom),
                                       v[63:32], 5'($urandom), 1'($urandom),
                                       1'($urandom), wide_value(), 1'(layers == 0)));
                for (int i = 0; i < layers; i++) begin
                    enqueue_item(random_item(OP_LAYER,
                                             1'($urandom_range(0, 4) != 0),
                                             1'(i == layers - 1 &&
                                                $urandom_range(0, 14) != 0)));
                end
            end
        end
        items_total = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (items_accepted == items_total);
        while (expected_sigs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_sigs.size() != 0) begin
            failures++;
            $display("%0d signatures never arrived", expected_sigs.size());
        end
        $display("Sent %0d items: %0d lists started, %0d missing layers.",
                 items_accepted, lists_started, absent_layers);
        $display("Checked %0d signatures, %0d mismatched.", sigs_checked, mismatches);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
